### sv/four_level_page_table_walker_unit_assert.svh
// Assertion macros shared by the page table walker RTL.
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_UNIT_ASSERT_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define FPTW_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Check a property on every clock edge, reset included.
`define FPTW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define FPTW_ASSERT(lbl, clk, rstn, prop, msg)
`define FPTW_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### sv/fptw_pkg.sv
// Types and constants of the four-level page table walker.
`timescale 1ns / 1ps

package fptw_pkg;

    localparam int TABLE_MEM_WORDS_DEF = 8192;

    localparam int ENTRY_W      = 64;
    localparam int WIDX_W       = 13;
    localparam int VA_W         = 48;
    localparam int PA_W         = 52;
    localparam int PFN_W        = 40;   // entry bits 51:12
    localparam int PAGE_OFS_W   = 12;
    localparam int IDX_W        = 9;    // table index slice per level
    localparam int WALK_WORD_W  = PFN_W + IDX_W;
    localparam int LVL_W        = 3;

    localparam int SHIFT_L4 = 39;
    localparam int SHIFT_L3 = 30;
    localparam int SHIFT_L2 = 21;
    localparam int SHIFT_L1 = 12;

    localparam int IN_TDATA_W  = 192;  // 189 bits of fields, padded to bytes
    localparam int OUT_TDATA_W = 120;  // 119 bits of fields, padded to bytes
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_ADDR_W  = 4;

    localparam logic [LVL_W-1:0] LVL_TOP  = 3'd4;
    localparam logic [LVL_W-1:0] LVL_LEAF = 3'd1;
    localparam logic [LVL_W-1:0] LVL_NONE = 3'd0;

    typedef enum logic [1:0] {
        CMD_WRITE     = 2'd0,
        CMD_READ      = 2'd1,
        CMD_TRANSLATE = 2'd2,
        CMD_SET_FLAGS = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NOT_PRESENT = 2'd1,
        ST_OUT_OF_MEM  = 2'd2
    } t_status;

    typedef enum logic {
        REG_ROOT_TABLE_ADDR = 1'b0
    } t_reg_idx;

endpackage

### sv/fptw_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module fptw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8192,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/four_level_page_table_walker_unit.sv
// Four-level page table walker with its own page table memory.
// One request is in flight at a time: a new request is taken only once the last result is
// handed to the output register; a held result stalls.
// Reset (synchronous, active low) zeroes the root register, then a clearing pass writes
// zero to all TABLE_MEM_WORDS table words, one per cycle; no request is taken meanwhile.
// Configuration writes are accepted during the clearing pass.
`timescale 1ns / 1ps

`include "four_level_page_table_walker_unit_assert.svh"

module four_level_page_table_walker_unit #(
    parameter int TABLE_MEM_WORDS = fptw_pkg::TABLE_MEM_WORDS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: entry_word_index[12:0], entry_data[76:13], walk_va[124:77],
    //        set_flags[188:125], zero pad[191:189]
    input  logic [fptw_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // tuser: cmd[1:0]
    input  logic [1:0]                          s_axis_tuser,
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: fault_level[2:0], phys_page_addr[54:3], read_data[118:55], zero pad[119]
    output logic [fptw_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // tuser: status[1:0]
    output logic [1:0]                          m_axis_tuser,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fptw_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [fptw_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [fptw_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int AW = $clog2(TABLE_MEM_WORDS);
    localparam int WW = fptw_pkg::WALK_WORD_W;
    localparam logic [WW-1:0] MEM_LIMIT = WW'(TABLE_MEM_WORDS);
    localparam logic [AW-1:0] CLR_LAST  = AW'(TABLE_MEM_WORDS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,    // zero the table memory after reset
        S_IDLE,     // wait for a request
        S_MEM,      // single-word write, or issue a single-word read
        S_RDATA,    // capture single-word read data
        S_WADDR,    // form the entry address of this level, range check, issue read
        S_WDATA,    // check present bit, OR flags, write back, step to next level
        S_FIN       // hand the result to the output register
    } t_state;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state                          r_state, n_state;
    logic [AW-1:0]                   r_clr, n_clr;
    logic [fptw_pkg::PA_W-1:0]       r_root, n_root;

    // captured request
    fptw_pkg::t_cmd                  r_cmd, n_cmd;
    logic [fptw_pkg::WIDX_W-1:0]     r_widx, n_widx;
    logic [fptw_pkg::ENTRY_W-1:0]    r_data, n_data;
    logic [fptw_pkg::VA_W-1:0]       r_va, n_va;
    logic [fptw_pkg::ENTRY_W-1:0]    r_flags, n_flags;

    // walk state
    logic [fptw_pkg::LVL_W-1:0]      r_lvl, n_lvl;
    logic [fptw_pkg::PFN_W-1:0]      r_base, n_base;
    logic [AW-1:0]                   r_waddr, n_waddr;

    // result being built
    fptw_pkg::t_status               r_status, n_status;
    logic [fptw_pkg::LVL_W-1:0]      r_flvl, n_flvl;
    logic [fptw_pkg::PA_W-1:0]       r_phys, n_phys;
    logic [fptw_pkg::ENTRY_W-1:0]    r_rd, n_rd;

    // output register
    logic                            r_o_valid, n_o_valid;
    fptw_pkg::t_status               r_o_status, n_o_status;
    logic [fptw_pkg::LVL_W-1:0]      r_o_flvl, n_o_flvl;
    logic [fptw_pkg::PA_W-1:0]       r_o_phys, n_o_phys;
    logic [fptw_pkg::ENTRY_W-1:0]    r_o_rd, n_o_rd;

    // RAM port
    logic                            ram_we;
    logic [AW-1:0]                   ram_waddr;
    logic [fptw_pkg::ENTRY_W-1:0]    ram_wdata;
    logic [AW-1:0]                   ram_raddr;
    logic [fptw_pkg::ENTRY_W-1:0]    ram_rdata;

    // shared per-level unit
    logic [fptw_pkg::IDX_W-1:0]      lvl_idx;
    logic [WW-1:0]                   walk_word;
    logic                            walk_oom;
    logic [WW-1:0]                   widx_word;
    logic                            widx_oom;
    logic [fptw_pkg::ENTRY_W-1:0]    entry_upd;
    logic                            entry_absent;

    logic                            in_accept;
    logic                            cfg_wr;

    fptw_ram #(
        .WIDTH (fptw_pkg::ENTRY_W),
        .DEPTH (TABLE_MEM_WORDS)
    ) u_table_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Handshakes and configuration
    // ------------------------------------------------------------------
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Registers sit every 8 bytes; paddr[3] picks the register slot.
    always_comb begin
        prdata = '0;
        if (paddr[3] == fptw_pkg::REG_ROOT_TABLE_ADDR) begin
            prdata = {{(fptw_pkg::CFG_DATA_W - fptw_pkg::PA_W){1'b0}}, r_root};
        end
    end

    // ------------------------------------------------------------------
    // Shared per-level unit: index slice, entry word address, range check,
    // present check and flag merge.
    // ------------------------------------------------------------------
    always_comb begin
        case (r_lvl)
            3'd4:    lvl_idx = r_va[fptw_pkg::SHIFT_L4 +: fptw_pkg::IDX_W];
            3'd3:    lvl_idx = r_va[fptw_pkg::SHIFT_L3 +: fptw_pkg::IDX_W];
            3'd2:    lvl_idx = r_va[fptw_pkg::SHIFT_L2 +: fptw_pkg::IDX_W];
            default: lvl_idx = r_va[fptw_pkg::SHIFT_L1 +: fptw_pkg::IDX_W];
        endcase
    end

    // The table base is 4 KiB aligned, so base/8 + index is a plain concatenation.
    assign walk_word = {r_base, lvl_idx};
    assign walk_oom  = (walk_word >= MEM_LIMIT);

    assign widx_word = {{(WW - fptw_pkg::WIDX_W){1'b0}}, r_widx};
    assign widx_oom  = (widx_word >= MEM_LIMIT);

    // The leaf level never checks the present bit.
    assign entry_absent = (r_lvl != fptw_pkg::LVL_LEAF) && !ram_rdata[0];
    assign entry_upd    = (r_cmd == fptw_pkg::CMD_SET_FLAGS) ? (ram_rdata | r_flags)
                                                              : ram_rdata;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_root     = r_root;
        n_cmd      = r_cmd;
        n_widx     = r_widx;
        n_data     = r_data;
        n_va       = r_va;
        n_flags    = r_flags;
        n_lvl      = r_lvl;
        n_base     = r_base;
        n_waddr    = r_waddr;
        n_status   = r_status;
        n_flvl     = r_flvl;
        n_phys     = r_phys;
        n_rd       = r_rd;
        n_o_valid  = r_o_valid;
        n_o_status = r_o_status;
        n_o_flvl   = r_o_flvl;
        n_o_phys   = r_o_phys;
        n_o_rd     = r_o_rd;

        ram_we    = 1'b0;
        ram_waddr = r_waddr;
        ram_wdata = entry_upd;
        ram_raddr = walk_word[AW-1:0];

        // Drop the held result once the consumer takes it.
        if (r_o_valid && m_axis_tready) begin
            n_o_valid = 1'b0;
        end

        if (cfg_wr && (paddr[3] == fptw_pkg::REG_ROOT_TABLE_ADDR)) begin
            n_root = pwdata[fptw_pkg::PA_W-1:0];
        end

        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                n_clr     = r_clr + AW'(1);
                if (r_clr == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (in_accept) begin
                    n_cmd    = fptw_pkg::t_cmd'(s_axis_tuser);
                    n_widx   = s_axis_tdata[12:0];
                    n_data   = s_axis_tdata[76:13];
                    n_va     = s_axis_tdata[124:77];
                    n_flags  = s_axis_tdata[188:125];
                    n_lvl    = fptw_pkg::LVL_TOP;
                    n_base   = r_root[fptw_pkg::PA_W-1:fptw_pkg::PAGE_OFS_W];
                    n_status = fptw_pkg::ST_OK;
                    n_flvl   = fptw_pkg::LVL_NONE;
                    n_phys   = '0;
                    n_rd     = '0;
                    if (s_axis_tuser == fptw_pkg::CMD_WRITE ||
                        s_axis_tuser == fptw_pkg::CMD_READ) begin
                        n_state = S_MEM;
                    end else begin
                        n_state = S_WADDR;
                    end
                end
            end

            S_MEM: begin
                ram_waddr = AW'(r_widx);
                ram_wdata = r_data;
                ram_raddr = AW'(r_widx);
                if (widx_oom) begin
                    n_status = fptw_pkg::ST_OUT_OF_MEM;
                    n_state  = S_FIN;
                end else if (r_cmd == fptw_pkg::CMD_WRITE) begin
                    ram_we  = 1'b1;
                    n_state = S_FIN;
                end else begin
                    n_state = S_RDATA;
                end
            end

            S_RDATA: begin
                n_rd    = ram_rdata;
                n_state = S_FIN;
            end

            S_WADDR: begin
                // Read issues on walk_word; hold its address for the write-back.
                n_waddr = walk_word[AW-1:0];
                if (walk_oom) begin
                    n_status = fptw_pkg::ST_OUT_OF_MEM;
                    n_flvl   = r_lvl;
                    n_state  = S_FIN;
                end else begin
                    n_state = S_WDATA;
                end
            end

            S_WDATA: begin
                if (entry_absent) begin
                    n_status = fptw_pkg::ST_NOT_PRESENT;
                    n_flvl   = r_lvl;
                    n_state  = S_FIN;
                end else begin
                    ram_we = (r_cmd == fptw_pkg::CMD_SET_FLAGS);
                    // Next base comes from the updated entry.
                    n_base = entry_upd[fptw_pkg::PA_W-1:fptw_pkg::PAGE_OFS_W];
                    if (r_lvl == fptw_pkg::LVL_LEAF) begin
                        if (r_cmd == fptw_pkg::CMD_TRANSLATE) begin
                            n_phys = {entry_upd[fptw_pkg::PA_W-1:fptw_pkg::PAGE_OFS_W],
                                      {fptw_pkg::PAGE_OFS_W{1'b0}}};
                        end
                        n_state = S_FIN;
                    end else begin
                        n_lvl   = r_lvl - fptw_pkg::LVL_W'(1);
                        n_state = S_WADDR;
                    end
                end
            end

            S_FIN: begin
                // Hold here until the output register is free.
                if (!r_o_valid || m_axis_tready) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_status;
                    n_o_flvl   = r_flvl;
                    n_o_phys   = r_phys;
                    n_o_rd     = r_rd;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_root    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_root    <= n_root;
            r_o_valid <= n_o_valid;
        end
        r_cmd      <= n_cmd;
        r_widx     <= n_widx;
        r_data     <= n_data;
        r_va       <= n_va;
        r_flags    <= n_flags;
        r_lvl      <= n_lvl;
        r_base     <= n_base;
        r_waddr    <= n_waddr;
        r_status   <= n_status;
        r_flvl     <= n_flvl;
        r_phys     <= n_phys;
        r_rd       <= n_rd;
        r_o_status <= n_o_status;
        r_o_flvl   <= n_o_flvl;
        r_o_phys   <= n_o_phys;
        r_o_rd     <= n_o_rd;
    end

    // ------------------------------------------------------------------
    // Result stream
    // ------------------------------------------------------------------
    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tuser  = r_o_status;
    assign m_axis_tdata  = {1'b0, r_o_rd, r_o_phys, r_o_flvl};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `FPTW_ASSERT(a_no_req_in_clear, i_clk, i_rst_n,
        (r_state == S_CLEAR) |-> !s_axis_tready, "request taken during clearing pass")
    `FPTW_ASSERT(a_busy_after_accept, i_clk, i_rst_n,
        in_accept |=> !s_axis_tready, "request taken while a walk is in progress")
    `FPTW_ASSERT(a_walk_wb_only_flags, i_clk, i_rst_n,
        (ram_we && (r_state == S_WDATA)) |-> (r_cmd == fptw_pkg::CMD_SET_FLAGS),
        "table write-back on a walk that is not a flag update")
    `FPTW_ASSERT(a_walk_level_range, i_clk, i_rst_n,
        ((r_state == S_WADDR) || (r_state == S_WDATA)) |->
            ((r_lvl != fptw_pkg::LVL_NONE) && (r_lvl <= fptw_pkg::LVL_TOP)),
        "walk level out of range")
    `FPTW_ASSERT(a_ok_no_fault_level, i_clk, i_rst_n,
        (m_axis_tvalid && (m_axis_tuser == fptw_pkg::ST_OK)) |->
            (r_o_flvl == fptw_pkg::LVL_NONE),
        "ok result carries a fault level")

endmodule

### tb/fptw_walk_checker.sv
// Checker for the page table walker: predicts every result and compares it.
`timescale 1ns / 1ps

module fptw_walk_checker
    import fptw_pkg::*;
#(
    parameter int TABLE_WORDS = TABLE_MEM_WORDS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_req_valid,
    input  logic                    i_req_ready,
    // request tdata: entry_word_index, entry_data, walk_va, set_flags, pad
    input  logic [IN_TDATA_W-1:0]   i_req_data,
    // request tuser: cmd
    input  logic [1:0]              i_req_user,
    input  logic                    i_res_valid,
    input  logic                    i_res_ready,
    // result tdata: fault_level, phys_page_addr, read_data, pad
    input  logic [OUT_TDATA_W-1:0]  i_res_data,
    // result tuser: status
    input  logic [1:0]              i_res_user,
    input  logic                    i_psel,
    input  logic                    i_penable,
    input  logic                    i_pwrite,
    input  logic [CFG_ADDR_W-1:0]   i_paddr,
    input  logic [CFG_DATA_W-1:0]   i_pwdata,
    input  logic                    i_pready,
    output int                      o_fail_count,
    output int                      o_pending
);

    localparam logic [CFG_ADDR_W-1:0] ROOT_ADDR =
        CFG_ADDR_W'(8 * int'(REG_ROOT_TABLE_ADDR));

    typedef struct packed {
        t_status             status;
        logic [LVL_W-1:0]    level;
        logic [PA_W-1:0]     phys;
        logic [ENTRY_W-1:0]  rdata;
    } t_walk_result;

    logic [ENTRY_W-1:0] table_shadow [TABLE_WORDS];
    logic [PA_W-1:0]    root_shadow = '0;
    t_walk_result       expected_walk_results [$];
    t_walk_result       want;
    int                 mismatch_count = 0;
    int                 outstanding = 0;

    assign o_fail_count = mismatch_count;
    assign o_pending    = outstanding;

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        $display("ERROR at %0t ns: %s got %h, want %h", $time, field, got, exp_val);
        mismatch_count++;
    endtask

    // Apply one request to the shadow tables and return its result.
    function automatic t_walk_result predict_walk_result(
        input t_cmd               cmd,
        input logic [WIDX_W-1:0]  widx,
        input logic [ENTRY_W-1:0] data,
        input logic [VA_W-1:0]    va,
        input logic [ENTRY_W-1:0] flags
    );
        t_walk_result       res;
        logic [PA_W-1:0]    base;
        logic [ENTRY_W-1:0] entry;
        logic [63:0]        word;
        logic [IDX_W-1:0]   idx;
        int                 lvl;
        bit                 stopped;
        res        = '0;
        res.status = ST_OK;
        res.level  = LVL_NONE;
        case (cmd)
            CMD_WRITE, CMD_READ: begin
                if (widx >= TABLE_WORDS) begin
                    res.status = ST_OUT_OF_MEM;
                end else if (cmd == CMD_WRITE) begin
                    table_shadow[widx] = data;
                end else begin
                    res.rdata = table_shadow[widx];
                end
            end
            default: begin
                base    = {root_shadow[PA_W-1:PAGE_OFS_W], {PAGE_OFS_W{1'b0}}};
                stopped = 1'b0;
                for (lvl = 4; lvl >= 1; lvl--) begin
                    if (!stopped) begin
                        idx  = va[SHIFT_L1 + IDX_W * (lvl - 1) +: IDX_W];
                        word = 64'(base[PA_W-1:3]) + 64'(idx);
                        if (word >= TABLE_WORDS) begin
                            res.status = ST_OUT_OF_MEM;
                            res.level  = LVL_W'(lvl);
                            stopped    = 1'b1;
                        end else begin
                            entry = table_shadow[word];
                            // the leaf is never checked for presence
                            if (lvl > 1 && !entry[0]) begin
                                res.status = ST_NOT_PRESENT;
                                res.level  = LVL_W'(lvl);
                                stopped    = 1'b1;
                            end else begin
                                if (cmd == CMD_SET_FLAGS) begin
                                    entry              = entry | flags;
                                    table_shadow[word] = entry;
                                end
                                base = {entry[PA_W-1:PAGE_OFS_W], {PAGE_OFS_W{1'b0}}};
                                if (lvl == 1 && cmd == CMD_TRANSLATE)
                                    res.phys = base;
                            end
                        end
                    end
                end
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_WORDS; i++)
                table_shadow[i] = '0;
            root_shadow = '0;
            expected_walk_results.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == ROOT_ADDR)
                root_shadow = i_pwdata[PA_W-1:0];
            if (i_req_valid && i_req_ready)
                expected_walk_results.push_back(predict_walk_result(
                    t_cmd'(i_req_user), i_req_data[12:0], i_req_data[76:13],
                    i_req_data[124:77], i_req_data[188:125]));
            if (i_res_valid && i_res_ready) begin
                if (expected_walk_results.size() == 0) begin
                    report_mismatch("result with none expected", i_res_data[63:0], '0);
                end else begin
                    want = expected_walk_results.pop_front();
                    if (i_res_user !== want.status)
                        report_mismatch("status", 64'(i_res_user), 64'(want.status));
                    if (i_res_data[2:0] !== want.level)
                        report_mismatch("fault_level", 64'(i_res_data[2:0]), 64'(want.level));
                    if (i_res_data[54:3] !== want.phys)
                        report_mismatch("phys_page_addr", 64'(i_res_data[54:3]),
                                        64'(want.phys));
                    if (i_res_data[118:55] !== want.rdata)
                        report_mismatch("read_data", i_res_data[118:55], want.rdata);
                end
            end
        end
        outstanding <= expected_walk_results.size();
    end

endmodule

### tb/tb_top.sv
// Top of the page table walker testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
    import fptw_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int WALK_LATENCY = 12;       // longest walk plus margin
    localparam int CYCLE_LIMIT  = 400000;   // clearing pass + slowest run, several times over
    localparam int PHASES       = 5;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // tdata: entry_word_index, entry_data, walk_va, set_flags, zero pad
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    // tuser: cmd
    logic [1:0]             s_axis_tuser  = CMD_READ;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // tdata: fault_level, phys_page_addr, read_data, zero pad
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // tuser: status
    logic [1:0]             m_axis_tuser;

    logic                   psel    = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0]  paddr   = '0;
    logic [CFG_DATA_W-1:0]  pwdata  = '0;
    logic [CFG_DATA_W-1:0]  prdata;
    logic                   pready;

    int fail_count;
    int pending;

    // stimulus state
    int               requests_sent = 0;
    int               cycle_count   = 0;
    bit               tx_calm       = 1'b0;
    logic [39:0]      root_page     = '0;
    logic [VA_W-1:0]  recent_va [8];
    int               recent_n      = 0;
    logic [51:0]      phase_root [PHASES];
    int               phase_items [PHASES];
    int               target;
    int               lvl;
    logic [VA_W-1:0]  va;
    logic [VA_W-1:0]  va_a;
    logic [39:0]      base_page;
    logic [39:0]      next_page;
    logic [IDX_W-1:0] idx;
    logic [12:0]      last_word = '0;
    int               pick;

    // receiver stall state
    int rx_mode_left  = 0;
    int rx_stall_left = 0;
    bit rx_calm       = 1'b0;

    four_level_page_table_walker_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    fptw_walk_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (s_axis_tvalid),
        .i_req_ready  (s_axis_tready),
        .i_req_data   (s_axis_tdata),
        .i_req_user   (s_axis_tuser),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .i_res_user   (m_axis_tuser),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Abort the run if it hangs; the clearing pass after reset is counted in the limit.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side: alternate between calm stretches and stretches with random stalls,
    // mostly short, now and then long.
    always @(posedge i_clk) begin
        if (rx_mode_left == 0) begin
            rx_calm      = ($urandom_range(0, 3) == 0);
            rx_mode_left = $urandom_range(50, 300);
        end else begin
            rx_mode_left--;
        end
        if (rx_stall_left > 0) begin
            rx_stall_left--;
            m_axis_tready <= 1'b0;
        end else if (!rx_calm && $urandom_range(0, 5) == 0) begin
            rx_stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                        : $urandom_range(0, 2);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [12:0] rand_widx();
        return 13'($urandom);
    endfunction

    function automatic logic [47:0] rand_va();
        return 48'(rand64());
    endfunction

    // Build a table entry: high flag bits, next table page, low flag bits, present bit.
    function automatic logic [63:0] make_entry(input logic [39:0] pfn, input logic present,
                                               input logic [11:0] hi, input logic [10:0] lo);
        return {hi, pfn, lo, present};
    endfunction

    // Mostly flags that leave the address bits alone, so walks keep their paths.
    function automatic logic [63:0] pick_flags();
        if ($urandom_range(0, 9) < 7)
            return {12'($urandom), 40'h0, 11'($urandom), 1'($urandom)};
        return rand64();
    endfunction

    // Issue one request; hold it until accepted. Drop valid only when a gap follows.
    task automatic send_request(input t_cmd cmd, input logic [12:0] widx,
                                input logic [63:0] data, input logic [47:0] vaddr,
                                input logic [63:0] flags);
        int gap;
        int roll;
        roll = $urandom_range(0, 99);
        if (tx_calm || roll < 55)
            gap = 0;
        else if (roll < 95)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 40);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, flags, vaddr, data, widx};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        requests_sent++;
    endtask

    // Drop valid, wait for every outstanding result, then let a walk's worth of cycles pass.
    task automatic wait_walker_idle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (WALK_LATENCY) @(posedge i_clk);
    endtask

    // Write the root table address over the config port: setup cycle, then access cycle.
    task automatic write_root_table_addr(input logic [51:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(8 * int'(REG_ROOT_TABLE_ADDR));
        pwdata  <= {12'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        root_page = value[51:12];
    endtask

    initial begin
        // hold reset low at the start, then release it for good
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed part, root at reset value zero ----
        va_a = {9'd1, 9'd2, 9'd3, 9'd4, 12'hABC};
        // fresh memory reads back zero, at both ends
        send_request(CMD_READ, 13'd0, rand64(), rand_va(), rand64());
        send_request(CMD_READ, 13'd8191, rand64(), rand_va(), rand64());
        send_request(CMD_WRITE, 13'd8191, '1, rand_va(), rand64());
        send_request(CMD_READ, 13'd8191, rand64(), rand_va(), rand64());
        send_request(CMD_WRITE, 13'd0, '0, rand_va(), rand64());
        // empty top-level entries: walks stop at the top level
        send_request(CMD_TRANSLATE, rand_widx(), rand64(), '0, rand64());
        send_request(CMD_SET_FLAGS, rand_widx(), rand64(), '1, '1);
        // build a full path through pages 0 -> 1 -> 2 -> 3; leaf has present clear
        send_request(CMD_WRITE, {4'd0, 9'd1}, make_entry(40'd1, 1'b1, '0, '0), '0, '0);
        send_request(CMD_WRITE, {4'd1, 9'd2}, make_entry(40'd2, 1'b1, '0, '0), '0, '0);
        send_request(CMD_WRITE, {4'd2, 9'd3}, make_entry(40'd3, 1'b1, '0, '0), '0, '0);
        send_request(CMD_WRITE, {4'd3, 9'd4}, make_entry('1, 1'b0, '1, '0), '0, '0);
        // leaf is not checked for presence, so this succeeds with an all-ones page
        send_request(CMD_TRANSLATE, rand_widx(), rand64(), va_a, rand64());
        send_request(CMD_SET_FLAGS, rand_widx(), rand64(), va_a, 64'h8000_0000_0000_0006);
        send_request(CMD_READ, {4'd0, 9'd1}, rand64(), rand_va(), rand64());
        send_request(CMD_READ, {4'd3, 9'd4}, rand64(), rand_va(), rand64());
        // neighbouring leaf is zero: still ok, page zero
        send_request(CMD_TRANSLATE, rand_widx(), rand64(), {9'd1, 9'd2, 9'd3, 9'd5, 12'h0},
                     rand64());
        // clear present at level 2: set-flags stops there, upper levels keep their flags
        send_request(CMD_WRITE, {4'd2, 9'd3}, make_entry(40'd3, 1'b0, '0, '0), '0, '0);
        send_request(CMD_SET_FLAGS, rand_widx(), rand64(), va_a, 64'h10);
        send_request(CMD_READ, {4'd1, 9'd2}, rand64(), rand_va(), rand64());
        // level 2 points past the memory: leaf entry out of range
        send_request(CMD_WRITE, {4'd2, 9'd3}, make_entry(40'd20, 1'b1, '0, '0), '0, '0);
        send_request(CMD_TRANSLATE, rand_widx(), rand64(), va_a, rand64());
        // level 3 points far past the memory
        send_request(CMD_WRITE, {4'd1, 9'd2}, make_entry('1, 1'b1, '0, '0), '0, '0);
        send_request(CMD_TRANSLATE, rand_widx(), rand64(), va_a, rand64());
        // empty level-3 entry
        send_request(CMD_SET_FLAGS, rand_widx(), rand64(), {9'd1, 9'd9, 30'h0}, 64'h2);
        // flags that move the next table: base comes from the updated entry
        send_request(CMD_SET_FLAGS, rand_widx(), rand64(), va_a, 64'h0000_0000_0000_F000);

        // ---- random phases, each with its own root ----
        phase_root[0] = {40'd15, 12'h000};
        phase_root[1] = {40'($urandom_range(0, 15)), 12'($urandom)};
        phase_root[2] = '1;                   // every walk leaves memory at the top
        phase_root[3] = '0;
        phase_root[4] = {40'($urandom_range(0, 15)), 12'hFFF};
        phase_items   = '{170, 170, 30, 170, 170};

        for (int p = 0; p < PHASES; p++) begin
            wait_walker_idle();
            write_root_table_addr(phase_root[p]);
            target = requests_sent + phase_items[p];
            while (requests_sent < target) begin
                // flip between gapless runs and gappy runs now and then
                if ($urandom_range(0, 7) == 0)
                    tx_calm = !tx_calm;
                pick = $urandom_range(0, 99);
                if (pick < 55 && root_page < 16) begin
                    // well-formed path with random content, then walks over it
                    va = 48'(rand64());
                    recent_va[recent_n % 8] = va;
                    recent_n++;
                    base_page = root_page;
                    for (lvl = 4; lvl >= 1 && base_page < 16; lvl--) begin
                        idx = va[SHIFT_L1 + IDX_W * (lvl - 1) +: IDX_W];
                        if ($urandom_range(0, 9) == 0 || (lvl == 1 && $urandom_range(0, 1)))
                            next_page = 40'(rand64());
                        else
                            next_page = 40'($urandom_range(0, 15));
                        last_word = {base_page[3:0], idx};
                        send_request(CMD_WRITE, last_word,
                                     make_entry(next_page, ($urandom_range(0, 9) != 0),
                                                12'($urandom), 11'($urandom)),
                                     rand_va(), rand64());
                        base_page = next_page;
                    end
                    repeat ($urandom_range(1, 3))
                        send_request($urandom_range(0, 1) ? CMD_TRANSLATE : CMD_SET_FLAGS,
                                     rand_widx(), rand64(), va, pick_flags());
                    if ($urandom_range(0, 2) == 0)
                        send_request(CMD_READ, last_word, rand64(), rand_va(), rand64());
                end else if (pick < 75) begin
                    // revisit a recent path, which later requests may have altered
                    va = (recent_n > 0) ? recent_va[$urandom_range(0, (recent_n > 8 ? 8
                                                                   : recent_n) - 1)]
                                        : 48'(rand64());
                    send_request($urandom_range(0, 1) ? CMD_TRANSLATE : CMD_SET_FLAGS,
                                 rand_widx(), rand64(), va, pick_flags());
                end else if ($urandom_range(0, 1)) begin
                    send_request(CMD_WRITE, 13'($urandom), rand64(), rand_va(), rand64());
                end else begin
                    send_request(CMD_READ, $urandom_range(0, 1) ? last_word : 13'($urandom),
                                 rand64(), rand_va(), rand64());
                end
            end
        end

        // drain, then give the verdict
        wait_walker_idle();
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
